@@ hdl/crt_pkg.sv @@
// ----------------------------------------------------------------------------
// crt_pkg
// shared types and codes for the color run table
// ----------------------------------------------------------------------------
package crt_pkg;

  localparam int unsigned COLOR_W = 32;
  localparam int unsigned LEN_W   = 16;

  // operation codes
  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_ASSIGN = 1'b1;

  // configuration register indexes
  localparam logic REG_RGB_MODE    = 1'b0;
  localparam logic REG_DEFAULT_RGB = 1'b1;

  typedef enum logic [3:0] {
    CELL_HOLD = 4'b0001,
    CELL_ROT  = 4'b0010,
    CELL_DEL  = 4'b0100,
    CELL_INS  = 4'b1000
  } cell_op_e;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_SCAN  = 7'b0000010,
    ST_CALC  = 7'b0000100,
    ST_DEL   = 7'b0001000,
    ST_INS_E = 7'b0010000,
    ST_INS_S = 7'b0100000,
    ST_FIN   = 7'b1000000
  } state_e;

  typedef struct packed {
    cell_op_e             op;
    logic [COLOR_W-1:0]   ins_color;
    logic                 ins_rgb;
  } cell_ctrl_t;

endpackage

@@ hdl/crt_cell.sv @@
// ----------------------------------------------------------------------------
// crt_cell
// one change point of the line: rotates, closes gaps and opens slots
// ----------------------------------------------------------------------------
module crt_cell #(
  parameter int unsigned COL_W = 17,
  parameter int unsigned CNT_W = 7,
  parameter int unsigned IDX   = 0
) (
  input  logic                       clk_i,
  input  crt_pkg::cell_ctrl_t        ctrl_i,
  input  logic [CNT_W-1:0]           pos_i,
  input  logic [COL_W-1:0]           ins_col_i,
  input  logic [COL_W-1:0]           up_col_i,
  input  logic [crt_pkg::COLOR_W-1:0] up_color_i,
  input  logic                       up_rgb_i,
  input  logic [COL_W-1:0]           dn_col_i,
  input  logic [crt_pkg::COLOR_W-1:0] dn_color_i,
  input  logic                       dn_rgb_i,
  output logic [COL_W-1:0]           col_o,
  output logic [crt_pkg::COLOR_W-1:0] color_o,
  output logic                       rgb_o
);
  import crt_pkg::*;

  localparam logic [CNT_W-1:0] MY = CNT_W'(IDX);

  logic [COL_W-1:0]   col_q,   col_d;
  logic [COLOR_W-1:0] color_q, color_d;
  logic               rgb_q,   rgb_d;

  always_comb begin
    col_d   = col_q;
    color_d = color_q;
    rgb_d   = rgb_q;
    case (ctrl_i.op)
      CELL_ROT: begin
        col_d = up_col_i; color_d = up_color_i; rgb_d = up_rgb_i;
      end
      CELL_DEL: begin
        if (MY >= pos_i) begin
          col_d = up_col_i; color_d = up_color_i; rgb_d = up_rgb_i;
        end
      end
      CELL_INS: begin
        if (MY > pos_i) begin
          col_d = dn_col_i; color_d = dn_color_i; rgb_d = dn_rgb_i;
        end else if (MY == pos_i) begin
          col_d = ins_col_i; color_d = ctrl_i.ins_color; rgb_d = ctrl_i.ins_rgb;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    col_q   <= col_d;
    color_q <= color_d;
    rgb_q   <= rgb_d;
  end

  assign col_o   = col_q;
  assign color_o = color_q;
  assign rgb_o   = rgb_q;

endmodule

@@ hdl/color_run_table.sv @@
// ----------------------------------------------------------------------------
// color_run_table
// sorted change point list of one text line, lookup and range assign
// ----------------------------------------------------------------------------
// channel   direction  handshake                 word
// command   in         start && !busy            operation, column, length, color
// config    in         cfg_valid_i && cfg_ready  register index, data
// result    out        done_o, one cycle         color, rgb flag, overflow, count
//
// a lookup is one full rotation of the cell ring to scan; an assign adds
// a calculation step, then one delete step per dropped point and one insert
// step per inserted point
// reset empties the list and clears the configuration registers and the sequencer, no clearing pass
// the result strobe lasts one cycle and cannot be held off
// ----------------------------------------------------------------------------
module color_run_table #(
  parameter int unsigned MAX_POINTS  = 64,
  parameter int unsigned COLUMN_BITS = 16,
  localparam int unsigned CNT_W = $clog2(MAX_POINTS + 1)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // command
  input  logic                         start,
  output logic                         busy,
  input  logic                         operation_i,
  input  logic [COLUMN_BITS-1:0]       column_i,
  input  logic [crt_pkg::LEN_W-1:0]    length_i,
  input  logic [crt_pkg::COLOR_W-1:0]  new_color_i,
  input  logic                         new_is_rgb_i,
  // configuration
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic                         cfg_index_i,
  input  logic [crt_pkg::COLOR_W-1:0]  cfg_data_i,
  // result
  output logic                         done_o,
  output logic [crt_pkg::COLOR_W-1:0]  read_color_o,
  output logic                         read_is_rgb_o,
  output logic                         overflow_o,
  output logic [CNT_W-1:0]             point_count_o
);
  import crt_pkg::*;

  localparam int unsigned COL_W = COLUMN_BITS + 1;          // 1-based stored column
  localparam int unsigned IDX_W = $clog2(MAX_POINTS);
  localparam int unsigned SUM_W = ((COL_W > LEN_W) ? COL_W : LEN_W) + 1;
  localparam logic [COL_W-1:0] POS_MAX = '1;
  localparam logic [CNT_W:0]   CAP     = (CNT_W + 1)'(MAX_POINTS);
  localparam logic [IDX_W-1:0] LAST    = IDX_W'(MAX_POINTS - 1);

  // configuration registers
  logic               rgb_mode_q;
  logic [COLOR_W-1:0] default_rgb_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rgb_mode_q    <= 1'b0;
      default_rgb_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_RGB_MODE:    rgb_mode_q    <= cfg_data_i[0];
        REG_DEFAULT_RGB: default_rgb_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // default color in effect before the first point
  logic [COLOR_W-1:0] dflt_color;
  assign dflt_color = rgb_mode_q ? default_rgb_q : '0;

  // command decode: 1-based start and saturated end column
  logic [COL_W-1:0] start_col;
  logic [SUM_W-1:0] stop_sum;
  logic [COL_W-1:0] stop_col;
  assign start_col = COL_W'(column_i) + COL_W'(1);
  assign stop_sum  = SUM_W'(start_col) + SUM_W'(length_i);
  assign stop_col  = (stop_sum > SUM_W'(POS_MAX)) ? POS_MAX : stop_sum[COL_W-1:0];

  // sequencer
  state_e state_q, state_d;
  logic               accept;
  logic [IDX_W-1:0]   t_q;
  logic [CNT_W-1:0]   total_q;     // live points
  logic [CNT_W-1:0]   pre_q;       // points before the range start
  logic [CNT_W-1:0]   thru_q;      // points up to the range end
  logic [CNT_W-1:0]   del_q;       // points still to drop
  logic [CNT_W:0]     cnt_q;       // size of the rebuilt list
  logic               op_q, nf_q, ins_s_q, ins_e_q;
  logic [COL_W-1:0]   start_q, stop_q;
  logic [COLOR_W-1:0] nc_q;
  logic [COLOR_W-1:0] color_pre_q, color_thru_q;
  logic               rgb_pre_q, rgb_thru_q;
  logic               done_q, ovf_q, rd_rgb_q;
  logic [COLOR_W-1:0] rd_color_q;

  assign accept = start && !busy;
  assign busy   = (state_q != ST_IDLE);

  // cell ring
  logic [COL_W-1:0]   cell_col   [MAX_POINTS];
  logic [COLOR_W-1:0] cell_color [MAX_POINTS];
  logic               cell_rgb   [MAX_POINTS];
  cell_ctrl_t         ctrl;
  logic [COL_W-1:0]   ins_col;

  // head of the ring during the scan rotation
  logic head_live, head_pre, head_thru;
  assign head_live = (CNT_W'(t_q) < total_q);
  assign head_pre  = head_live && (cell_col[0] < start_q);
  assign head_thru = head_live && (cell_col[0] <= stop_q);

  // rebuilt size: kept points plus start and restore points
  logic           need_s, need_e;
  logic [CNT_W:0] cnt_calc;
  assign need_s   = (nc_q != color_pre_q) || (nf_q != rgb_pre_q);
  assign need_e   = (nc_q != color_thru_q) || (nf_q != rgb_thru_q);
  assign cnt_calc = (CNT_W + 1)'(total_q) - (CNT_W + 1)'(thru_q - pre_q)
                  + (CNT_W + 1)'(need_s) + (CNT_W + 1)'(need_e);

  always_comb begin
    ctrl.op        = CELL_HOLD;
    ctrl.ins_color = nc_q;
    ctrl.ins_rgb   = nf_q;
    ins_col        = start_q;
    case (state_q)
      ST_SCAN: ctrl.op = CELL_ROT;
      ST_DEL:  ctrl.op = CELL_DEL;
      ST_INS_E: begin
        ctrl.op        = CELL_INS;
        ctrl.ins_color = color_thru_q;
        ctrl.ins_rgb   = rgb_thru_q;
        ins_col        = stop_q;
      end
      ST_INS_S: ctrl.op = CELL_INS;
      default: ;
    endcase
  end

  for (genvar k = 0; k < MAX_POINTS; k++) begin : g_cell
    localparam int unsigned UP = (k == MAX_POINTS - 1) ? 0 : k + 1;
    localparam int unsigned DN = (k == 0) ? 0 : k - 1;
    crt_cell #(
      .COL_W (COL_W),
      .CNT_W (CNT_W),
      .IDX   (k)
    ) u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .pos_i      (pre_q),
      .ins_col_i  (ins_col),
      .up_col_i   (cell_col[UP]),
      .up_color_i (cell_color[UP]),
      .up_rgb_i   (cell_rgb[UP]),
      .dn_col_i   (cell_col[DN]),
      .dn_color_i (cell_color[DN]),
      .dn_rgb_i   (cell_rgb[DN]),
      .col_o      (cell_col[k]),
      .color_o    (cell_color[k]),
      .rgb_o      (cell_rgb[k])
    );
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (accept) state_d = ST_SCAN;
      ST_SCAN: begin
        if (t_q == LAST) state_d = (op_q == OP_ASSIGN) ? ST_CALC : ST_FIN;
      end
      ST_CALC: begin
        if (cnt_calc > CAP)         state_d = ST_FIN;
        else if (thru_q != pre_q)   state_d = ST_DEL;
        else if (need_e)            state_d = ST_INS_E;
        else if (need_s)            state_d = ST_INS_S;
        else                        state_d = ST_FIN;
      end
      ST_DEL: begin
        if (del_q == CNT_W'(1)) begin
          if (ins_e_q)      state_d = ST_INS_E;
          else if (ins_s_q) state_d = ST_INS_S;
          else              state_d = ST_FIN;
        end
      end
      ST_INS_E: state_d = ins_s_q ? ST_INS_S : ST_FIN;
      ST_INS_S: state_d = ST_FIN;
      ST_FIN:   state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      total_q <= '0;
      done_q  <= 1'b0;
      t_q     <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == ST_FIN);
      case (state_q)
        ST_SCAN: t_q <= t_q + IDX_W'(1);
        ST_FIN:  if (op_q == OP_ASSIGN && !ovf_q) total_q <= cnt_q[CNT_W-1:0];
        default: t_q <= '0;
      endcase
    end
  end

  // payload of the operation in flight
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          op_q         <= operation_i;
          nc_q         <= new_color_i;
          nf_q         <= new_is_rgb_i;
          start_q      <= start_col;
          // a lookup looks for the last point at or below its column
          stop_q       <= (operation_i == OP_ASSIGN) ? stop_col : start_col;
          pre_q        <= '0;
          thru_q       <= '0;
          color_pre_q  <= dflt_color;
          rgb_pre_q    <= rgb_mode_q;
          color_thru_q <= dflt_color;
          rgb_thru_q   <= rgb_mode_q;
          ovf_q        <= 1'b0;
        end
      end
      ST_SCAN: begin
        if (head_pre) begin
          pre_q       <= pre_q + CNT_W'(1);
          color_pre_q <= cell_color[0];
          rgb_pre_q   <= cell_rgb[0];
        end
        if (head_thru) begin
          thru_q       <= thru_q + CNT_W'(1);
          color_thru_q <= cell_color[0];
          rgb_thru_q   <= cell_rgb[0];
        end
      end
      ST_CALC: begin
        cnt_q   <= cnt_calc;
        ovf_q   <= (cnt_calc > CAP);
        del_q   <= thru_q - pre_q;
        ins_s_q <= need_s;
        ins_e_q <= need_e;
      end
      ST_DEL: del_q <= del_q - CNT_W'(1);
      ST_FIN: begin
        rd_color_q <= (op_q == OP_LOOKUP) ? color_thru_q : '0;
        rd_rgb_q   <= (op_q == OP_LOOKUP) ? rgb_thru_q : 1'b0;
      end
      default: ;
    endcase
  end

  assign done_o        = done_q;
  assign read_color_o  = rd_color_q;
  assign read_is_rgb_o = rd_rgb_q;
  assign overflow_o    = ovf_q;
  assign point_count_o = total_q;

  // checks
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("result strobe longer than one cycle");

  a_total_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= CNT_W'(MAX_POINTS)) else $error("point count above capacity");

  a_ovf_assign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && ovf_q) |-> (op_q == OP_ASSIGN)) else $error("overflow on lookup");

  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy) else $error("command accepted but block idle");

  a_prefix_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CALC) |-> (pre_q <= thru_q)) else $error("range prefix past range end");

endmodule

@@ tb/sv/color_run_table_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// color_run_table_test
// self-checking bench: directed table then random lookups and range assigns,
// every result word compared with a typed word or an in-bench model of the change point list
// ----------------------------------------------------------------------------
module color_run_table_test;
  import crt_pkg::*;

  localparam int unsigned NPTS  = 64;
  localparam int unsigned COLW  = 16;
  localparam int unsigned CNTW  = $clog2(NPTS + 1);
  localparam int unsigned NDIR  = 22;
  localparam int unsigned NRAND = 1250;
  localparam logic [COLW:0] POS_LIMIT = {(COLW + 1){1'b1}};

  typedef struct packed {
    logic [COLOR_W-1:0] color;
    logic               rgb;
    logic               ovf;
    logic [CNTW-1:0]    count;
  } result_t;

  typedef struct {
    logic               op;
    logic [COLW-1:0]    col;
    logic [LEN_W-1:0]   len;
    logic [COLOR_W-1:0] color;
    logic               rgb;
    logic               known;   // expected word typed in below
    result_t            res;
  } row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic                operation_i = OP_LOOKUP;
  logic [COLW-1:0]     column_i = '0;
  logic [LEN_W-1:0]    length_i = '0;
  logic [COLOR_W-1:0]  new_color_i = '0;
  logic                new_is_rgb_i = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic                cfg_index_i = REG_RGB_MODE;
  logic [COLOR_W-1:0]  cfg_data_i = '0;
  logic                done_o;
  logic [COLOR_W-1:0]  read_color_o;
  logic                read_is_rgb_o;
  logic                overflow_o;
  logic [CNTW-1:0]     point_count_o;

  color_run_table #(.MAX_POINTS(NPTS), .COLUMN_BITS(COLW)) dut (.*);

  initial forever #2 clk_i = ~clk_i;

  // model copy of the registers and the list
  logic               m_rgb_mode;
  logic [COLOR_W-1:0] m_default;
  int unsigned        m_total;
  logic [COLW:0]      m_pcol [NPTS];
  logic [COLOR_W-1:0] m_pclr [NPTS];
  logic               m_prgb [NPTS];

  result_t            pending_words[$];
  int unsigned        mismatches = 0;
  row_t               dir_rows[NDIR];

  function automatic result_t paint_and_read(logic op, logic [COLW-1:0] col,
      logic [LEN_W-1:0] len, logic [COLOR_W-1:0] nc, logic nf);
    result_t r;
    logic [COLOR_W-1:0] oc;
    logic of;
    logic [COLW:0] first, last;
    logic [COLW:0] bcol [NPTS + 2];
    logic [COLOR_W-1:0] bclr [NPTS + 2];
    logic brgb [NPTS + 2];
    int unsigned i, cnt;
    logic [COLW+1:0] wide;
    r = '0;
    i = 0;
    cnt = 0;
    oc = m_rgb_mode ? m_default : '0;
    of = m_rgb_mode;
    first = {1'b0, col} + 1'b1;
    if (op == OP_LOOKUP) begin
      while (i < m_total && m_pcol[i] <= first) begin
        oc = m_pclr[i]; of = m_prgb[i]; i++;
      end
      r.color = oc;
      r.rgb = of;
    end else begin
      wide = first + len;
      last = (wide > POS_LIMIT) ? POS_LIMIT : wide[COLW:0];
      while (i < m_total && m_pcol[i] < first) begin
        oc = m_pclr[i]; of = m_prgb[i];
        bcol[cnt] = m_pcol[i]; bclr[cnt] = oc; brgb[cnt] = of;
        cnt++; i++;
      end
      if (nc != oc || nf != of) begin
        bcol[cnt] = first; bclr[cnt] = nc; brgb[cnt] = nf; cnt++;
      end
      while (i < m_total && m_pcol[i] <= last) begin
        oc = m_pclr[i]; of = m_prgb[i]; i++;
      end
      // list holds at most NPTS, so the rebuilt list exceeds it by two at most
      if (nc != oc || nf != of) begin
        bcol[cnt] = last; bclr[cnt] = oc; brgb[cnt] = of; cnt++;
      end
      while (i < m_total) begin
        bcol[cnt] = m_pcol[i]; bclr[cnt] = m_pclr[i]; brgb[cnt] = m_prgb[i];
        cnt++; i++;
      end
      if (cnt > NPTS) r.ovf = 1'b1;
      else begin
        for (int k = 0; k < cnt; k++) begin
          m_pcol[k] = bcol[k]; m_pclr[k] = bclr[k]; m_prgb[k] = brgb[k];
        end
        m_total = cnt;
      end
    end
    r.count = m_total[CNTW-1:0];
    return r;
  endfunction

  // result side: every done cycle takes the oldest expected word
  always @(posedge clk_i) begin
    result_t got, want;
    if (rst_ni && done_o) begin
      got = '{read_color_o, read_is_rgb_o, overflow_o, point_count_o};
      if (pending_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %h", got);
      end else begin
        want = pending_words.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: color %h/%h rgb %b/%b ovf %b/%b count %0d/%0d",
                     want.color, got.color, want.rgb, got.rgb,
                     want.ovf, got.ovf, want.count, got.count);
        end
      end
    end
  end

  task automatic write_reg(logic idx, logic [COLOR_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == REG_RGB_MODE) m_rgb_mode = val[0];
    else m_default = val;
    // valid low for one cycle before the next write
    @(posedge clk_i);
  endtask

  // wait for all words, then let the block settle before touching registers
  task automatic drain;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (2 * NPTS + 10) @(posedge clk_i);
  endtask

  task automatic random_gap;
    int unsigned g;
    g = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 300) : $urandom_range(0, 3);
    repeat (g) @(posedge clk_i);
  endtask

  task automatic send_word(logic op, logic [COLW-1:0] col, logic [LEN_W-1:0] len,
      logic [COLOR_W-1:0] nc, logic nf, logic known, result_t typed);
    result_t pr;
    start <= 1'b1;
    operation_i <= op;
    column_i <= col;
    length_i <= len;
    new_color_i <= nc;
    new_is_rgb_i <= nf;
    do @(posedge clk_i); while (busy);
    start <= 1'b0;
    pr = paint_and_read(op, col, len, nc, nf);
    pending_words.push_back(known ? typed : pr);
    // start low for one cycle before the next word
    @(posedge clk_i);
  endtask

  function automatic row_t mk(logic op, logic [COLW-1:0] col, logic [LEN_W-1:0] len,
      logic [COLOR_W-1:0] nc, logic nf, logic known = 1'b0, result_t res = '0);
    mk = '{op, col, len, nc, nf, known, res};
  endfunction

  initial begin
    logic [COLW-1:0] rc;
    logic [LEN_W-1:0] rl;
    logic [COLOR_W-1:0] palette [4];
    m_rgb_mode = 1'b0;
    m_default = '0;
    m_total = 0;
    // directed table: extremes, zero length, same color, range at the end
    dir_rows[0]  = mk(OP_LOOKUP, 16'd0, 16'd0, 32'd0, 1'b0, 1'b1, '{32'd0, 1'b0, 1'b0, 7'd0});
    dir_rows[1]  = mk(OP_LOOKUP, 16'hFFFE, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 1'b1,
                      '{32'd0, 1'b0, 1'b0, 7'd0});
    // same color as the default: no point added
    dir_rows[2]  = mk(OP_ASSIGN, 16'd5, 16'd10, 32'd0, 1'b0, 1'b1, '{32'd0, 1'b0, 1'b0, 7'd0});
    dir_rows[3]  = mk(OP_ASSIGN, 16'd5, 16'd10, 32'h0000_0007, 1'b0, 1'b1,
                      '{32'd0, 1'b0, 1'b0, 7'd2});
    dir_rows[4]  = mk(OP_LOOKUP, 16'd5, 16'd0, 32'd0, 1'b0, 1'b1,
                      '{32'h0000_0007, 1'b0, 1'b0, 7'd2});
    dir_rows[5]  = mk(OP_LOOKUP, 16'd15, 16'd0, 32'd0, 1'b0);
    dir_rows[6]  = mk(OP_LOOKUP, 16'd4, 16'd0, 32'd0, 1'b0);
    // same word, other flag counts as another color
    dir_rows[7]  = mk(OP_ASSIGN, 16'd7, 16'd2, 32'h0000_0007, 1'b1);
    dir_rows[8]  = mk(OP_LOOKUP, 16'd7, 16'd0, 32'd0, 1'b0);
    // zero length: start and restore share a column
    dir_rows[9]  = mk(OP_ASSIGN, 16'd30, 16'd0, 32'hDEAD_BEEF, 1'b1);
    dir_rows[10] = mk(OP_LOOKUP, 16'd29, 16'd0, 32'd0, 1'b0);
    dir_rows[11] = mk(OP_LOOKUP, 16'd30, 16'd0, 32'd0, 1'b0);
    dir_rows[12] = mk(OP_ASSIGN, 16'hFFFE, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);
    dir_rows[13] = mk(OP_LOOKUP, 16'hFFFE, 16'd0, 32'd0, 1'b0);
    dir_rows[14] = mk(OP_ASSIGN, 16'd0, 16'hFFFF, 32'h1234_5678, 1'b0);
    dir_rows[15] = mk(OP_LOOKUP, 16'd0, 16'd0, 32'd0, 1'b0);
    dir_rows[16] = mk(OP_LOOKUP, 16'hFFFE, 16'd0, 32'd0, 1'b0);
    dir_rows[17] = mk(OP_ASSIGN, 16'd100, 16'd1, 32'h5555_AAAA, 1'b1);
    dir_rows[18] = mk(OP_ASSIGN, 16'd99, 16'd3, 32'hAAAA_5555, 1'b0);
    dir_rows[19] = mk(OP_LOOKUP, 16'd100, 16'd0, 32'd0, 1'b0);
    dir_rows[20] = mk(OP_ASSIGN, 16'd0, 16'hFFFF, 32'd0, 1'b0);
    dir_rows[21] = mk(OP_LOOKUP, 16'd1000, 16'd0, 32'd0, 1'b0);

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[k])
      send_word(dir_rows[k].op, dir_rows[k].col, dir_rows[k].len, dir_rows[k].color,
                dir_rows[k].rgb, dir_rows[k].known, dir_rows[k].res);
    drain();

    // random phases, each under its own register setting
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin write_reg(REG_RGB_MODE, 32'd1); write_reg(REG_DEFAULT_RGB, 32'hFFFF_FFFF); end
        1: begin write_reg(REG_DEFAULT_RGB, 32'd0); end
        2: begin write_reg(REG_RGB_MODE, 32'd0); write_reg(REG_DEFAULT_RGB, $urandom); end
        3: begin write_reg(REG_RGB_MODE, 32'd1); write_reg(REG_DEFAULT_RGB, $urandom); end
        default: begin write_reg(REG_RGB_MODE, 32'd0); end
      endcase
      // small palette so colors often repeat and merge
      palette[0] = 32'd0;
      palette[1] = m_default;
      palette[2] = $urandom;
      palette[3] = $urandom;
      for (int n = 0; n < NRAND / 5; n++) begin
        // mostly narrow columns so the table fills and overflows
        rc = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 16'hFFFE))
                                         : 16'($urandom_range(0, 200));
        case ($urandom_range(0, 3))
          0: rl = 16'd0;
          1: rl = 16'($urandom_range(1, 4));
          2: rl = 16'($urandom_range(0, 40));
          default: rl = 16'($urandom);
        endcase
        if (ph == 4 && $urandom_range(0, 1)) rl = 16'($urandom_range(0, 2));
        send_word($urandom_range(0, 2) != 0 ? OP_ASSIGN : OP_LOOKUP, rc, rl,
                  $urandom_range(0, 4) == 0 ? $urandom : palette[$urandom_range(0, 3)],
                  1'($urandom), 1'b0, '0);
        if (n == 100) begin
          // hold off until the block has answered everything
          while (pending_words.size() != 0) @(posedge clk_i);
        end
        if ($urandom_range(0, 3) == 0) random_gap();
      end
      drain();
    end

    if (mismatches == 0 && pending_words.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20ms;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
